FILE: hw/rtl/puf_pkg.sv
// ----------------------------------------------------------------------------
// puf_pkg
// Shared types and constants of the parity union-find block.
// ----------------------------------------------------------------------------
package puf_pkg;

    localparam int ID_W         = 10;
    localparam int CNT_W        = 16;
    localparam int HAP_W        = 2;
    localparam int NUM_SETS_DEF = 1024;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [HAP_W-1:0] HAP_SUM   = 2'd3;
    localparam logic [HAP_W-1:0] HAP_ONE   = 2'd1;
    localparam logic [HAP_W-1:0] HAP_TWO   = 2'd2;

    localparam logic OP_LINK    = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    // One table entry: present flag, parity to parent, parent id.
    typedef struct packed {
        logic            present;
        logic            parity;
        logic [ID_W-1:0] parent;
    } node_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHK_A,
        ST_CHK_B,
        ST_WALK,
        ST_COMP,
        ST_UNION,
        ST_OUT
    } state_t;

    // Which find is running.
    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } phase_t;

endpackage

FILE: hw/rtl/parity_union_find.sv
// ----------------------------------------------------------------------------
// parity_union_find
// Disjoint-set table with a parity bit per node and path compression.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transfer per item. s_tuser is the opcode, link or
// resolve; s_tdata carries the two set ids, the flip flag and the haplotype.
// Result stream (m_*): exactly one transfer per item, in order, carrying the
// root, its parity, the known flag, the oriented haplotype, the conflict flag
// and the saturating conflict total.
// The node table is one synchronous memory with one read and one write port.
// A find walks the parent chain one node per cycle and, unless it started
// at the root, walks it again to point every node straight at the root.
// A resolve checks its id, runs its find if the id is known, then writes its
// result; a link checks both ids, creating new ones, runs the finds of its
// known ids, then joins the two roots, or checks their parity when they are
// the same, before writing its result.
// An item is processed while the previous result still waits in the output
// register; the block holds in its last step until that register is free.
// After reset the table is swept clear, one entry per cycle, over all NUM_SETS
// entries; s_tready stays low during the sweep.
// ----------------------------------------------------------------------------
module parity_union_find
    import puf_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_id[9:0], second_id[19:10], flip[20], hap_in[22:21], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // root_id[9:0], root_parity[10], known[11], hap_out[13:12], conflict[14],
    // conflict_count[30:15], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    // node table
    node_t            mem [NUM_SETS];
    node_t            rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_t            wr_data;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // item
    logic             op_reg, op_next;
    logic [ID_W-1:0]  a_reg, a_next;
    logic [ID_W-1:0]  b_reg, b_next;
    logic             flip_reg, flip_next;
    logic [HAP_W-1:0] hap_reg, hap_next;
    logic             known_reg, known_next;
    logic             b_new_reg, b_new_next;
    logic             conflict_reg, conflict_next;

    // find
    logic [ID_W-1:0]  cur_reg, cur_next;
    logic [ID_W-1:0]  start_reg, start_next;
    logic [ID_W-1:0]  root_reg, root_next;
    logic             acc_reg, acc_next;
    logic             prefix_reg, prefix_next;
    logic [ID_W-1:0]  rl_reg, rl_next;
    logic             pl_reg, pl_next;
    logic [ID_W-1:0]  rr_reg, rr_next;
    logic             pr_reg, pr_next;

    logic             fd;
    logic [ID_W-1:0]  fd_root;
    logic             fd_par;
    logic             s_a_ok, b_ok;
    logic [HAP_W-1:0] hap_res;

    assign s_a_ok = 32'(s_tdata[ID_W-1:0]) < 32'(NUM_SETS);
    assign b_ok   = 32'(b_reg) < 32'(NUM_SETS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        m_tdata_reg  <= m_tdata_next;
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        flip_reg     <= flip_next;
        hap_reg      <= hap_next;
        known_reg    <= known_next;
        b_new_reg    <= b_new_next;
        conflict_reg <= conflict_next;
        cur_reg      <= cur_next;
        start_reg    <= start_next;
        root_reg     <= root_next;
        acc_reg      <= acc_next;
        prefix_reg   <= prefix_next;
        rl_reg       <= rl_next;
        pl_reg       <= pl_next;
        rr_reg       <= rr_next;
        pr_reg       <= pr_next;
    end

    always_comb begin
        hap_res = 2'd0;
        if (op_reg == OP_RESOLVE) begin
            hap_res = hap_reg;
            if (pl_reg && (hap_reg == HAP_ONE || hap_reg == HAP_TWO)) begin
                hap_res = HAP_SUM - hap_reg;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        flip_next     = flip_reg;
        hap_next      = hap_reg;
        known_next    = known_reg;
        b_new_next    = b_new_reg;
        conflict_next = conflict_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        root_next     = root_reg;
        acc_next      = acc_reg;
        prefix_next   = prefix_reg;
        rl_next       = rl_reg;
        pl_next       = pl_reg;
        rr_next       = rr_reg;
        pr_next       = pr_reg;
        rd_addr       = IDX_W'(cur_reg);
        wr_en         = 1'b0;
        wr_addr       = IDX_W'(cur_reg);
        wr_data       = '{present: 1'b1, parity: 1'b0, parent: cur_reg};
        s_tready      = 1'b0;
        fd            = 1'b0;
        fd_root       = cur_reg;
        fd_par        = acc_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = IDX_W'(s_tdata[ID_W-1:0]);
                if (s_tvalid) begin
                    op_next       = s_tuser;
                    a_next        = s_tdata[ID_W-1:0];
                    b_next        = s_tdata[2*ID_W-1:ID_W];
                    flip_next     = s_tdata[2*ID_W];
                    hap_next      = s_tdata[2*ID_W+HAP_W:2*ID_W+1];
                    conflict_next = 1'b0;
                    known_next    = 1'b0;
                    rl_next       = s_tdata[ID_W-1:0];
                    pl_next       = 1'b0;
                    state_next    = s_a_ok ? ST_CHK_A : ST_OUT;
                end
            end
            ST_CHK_A: begin
                known_next = rdata_reg.present;
                if (op_reg == OP_LINK) begin
                    if (b_ok) begin
                        // create the left node if new, fetch the right one
                        wr_en      = !rdata_reg.present;
                        wr_addr    = IDX_W'(a_reg);
                        wr_data    = '{present: 1'b1, parity: 1'b0, parent: a_reg};
                        rd_addr    = IDX_W'(b_reg);
                        state_next = ST_CHK_B;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else if (rdata_reg.present) begin
                    rd_addr    = IDX_W'(a_reg);
                    cur_next   = a_reg;
                    start_next = a_reg;
                    acc_next   = 1'b0;
                    phase_next = PH_R;
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_CHK_B: begin
                // a new node is its own root; when both ids match and are new,
                // the table read above missed the left write, so key on known
                b_new_next = !rdata_reg.present || (a_reg == b_reg && !known_reg);
                wr_en      = !rdata_reg.present;
                wr_addr    = IDX_W'(b_reg);
                wr_data    = '{present: 1'b1, parity: 1'b0, parent: b_reg};
                rr_next    = b_reg;
                pr_next    = 1'b0;
                if (!known_reg) begin
                    rl_next = a_reg;
                    pl_next = 1'b0;
                    if (!rdata_reg.present || a_reg == b_reg) begin
                        state_next = ST_UNION;
                    end else begin
                        rd_addr    = IDX_W'(b_reg);
                        cur_next   = b_reg;
                        start_next = b_reg;
                        acc_next   = 1'b0;
                        phase_next = PH_B;
                        state_next = ST_WALK;
                    end
                end else begin
                    rd_addr    = IDX_W'(a_reg);
                    cur_next   = a_reg;
                    start_next = a_reg;
                    acc_next   = 1'b0;
                    phase_next = PH_A;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rdata_reg.parent == cur_reg) begin
                    root_next = cur_reg;
                    if (cur_reg == start_reg) begin
                        fd = 1'b1;
                    end else begin
                        // rewind to the start and compress
                        rd_addr     = IDX_W'(start_reg);
                        cur_next    = start_reg;
                        prefix_next = 1'b0;
                        state_next  = ST_COMP;
                    end
                end else begin
                    acc_next = acc_reg ^ rdata_reg.parity;
                    cur_next = rdata_reg.parent;
                    rd_addr  = IDX_W'(rdata_reg.parent);
                end
            end
            ST_COMP: begin
                fd_root = root_reg;
                if (rdata_reg.parent == cur_reg) begin
                    fd = 1'b1;
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = IDX_W'(cur_reg);
                    wr_data     = '{present: 1'b1, parity: acc_reg ^ prefix_reg,
                                    parent: root_reg};
                    prefix_next = prefix_reg ^ rdata_reg.parity;
                    cur_next    = rdata_reg.parent;
                    rd_addr     = IDX_W'(rdata_reg.parent);
                end
            end
            ST_UNION: begin
                if (rl_reg == rr_reg) begin
                    if ((pl_reg ^ pr_reg) != flip_reg) begin
                        conflict_next = 1'b1;
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = IDX_W'(rr_reg);
                    wr_data = '{present: 1'b1, parity: pl_reg ^ pr_reg ^ flip_reg,
                                parent: rl_reg};
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({cnt_reg, conflict_reg, hap_res,
                                                known_reg, pl_reg, rl_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // hand a finished find to the next step of the item
        if (fd) begin
            unique case (phase_reg)
                PH_A: begin
                    rl_next = fd_root;
                    pl_next = fd_par;
                    if (b_new_reg) begin
                        state_next = ST_UNION;
                    end else begin
                        rd_addr    = IDX_W'(b_reg);
                        cur_next   = b_reg;
                        start_next = b_reg;
                        acc_next   = 1'b0;
                        phase_next = PH_B;
                        state_next = ST_WALK;
                    end
                end
                PH_B: begin
                    rr_next    = fd_root;
                    pr_next    = fd_par;
                    state_next = ST_UNION;
                end
                default: begin
                    rl_next    = fd_root;
                    pl_next    = fd_par;
                    state_next = ST_OUT;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the conflict total only grows
    a_cnt_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg >= $past(cnt_reg))
        else $error("conflict total decreased");

    // compression never rewrites the node it is about to read
    a_comp_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && wr_en) |-> wr_addr != rd_addr)
        else $error("compression write collides with read");

    // a stalled result is never overwritten by the next one
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> state_reg == ST_OUT)
        else $error("result loaded while output stalled");

    // no item is taken during the clearing sweep
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready && !m_tvalid_reg)
        else $error("activity during clearing sweep");

endmodule
